### rtl/sisiu_pkg.sv
// Shared types and constants for the sorted identifier set.
package sisiu_pkg;

  // Width of the position and entry count result fields
  localparam int POS_W = 11;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_INSERTED,
    EV_REMOVED,
    EV_RESET
  } ev_t;

  // Commands broadcast to every cell of the row
  typedef struct packed {
    logic capture;  // compare the entry against the key, hold the flags
    logic ins;      // open a slot at the insertion point and fill it
    logic rem;      // close the slot of the matching entry
  } cell_cmd_t;

endpackage

### rtl/sisiu_cell.sv
// One compare-and-shift cell of the sorted identifier row.
module sisiu_cell #(
  parameter int ID_W = 32
) (
  input  logic                  clk,
  input  logic [ID_W-1:0]       key,
  input  logic                  valid,
  input  sisiu_pkg::cell_cmd_t  cmd,
  input  logic                  left_ltv,
  input  logic [ID_W-1:0]       left_entry,
  input  logic [ID_W-1:0]       right_entry,
  output logic [ID_W-1:0]       entry,
  output logic                  ltv,
  output logic                  eqv
);

  // Hold the compare flags for the current item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ltv <= valid && (entry < key);
      eqv <= valid && (entry == key);
    end
  end

  // Shift right on insert, left on remove, at and after the insertion point
  always_ff @(posedge clk) begin
    if (cmd.ins && !ltv) begin
      entry <= left_ltv ? key : left_entry;
    end else if (cmd.rem && !ltv) begin
      entry <= right_entry;
    end
  end

endmodule

### rtl/sisiu_tree.sv
// Registered four-way reduction that picks the data of the single hit leaf.
module sisiu_tree #(
  parameter int N = 1024,
  parameter int W = 11
) (
  input  logic                  clk,
  input  logic [N-1:0]          hit,
  input  logic [N-1:0][W-1:0]   data,
  output logic                  any,
  output logic [W-1:0]          sel
);

  localparam int LEVELS = ($clog2(N) + 1) / 2;
  localparam int P      = 4 ** LEVELS;

  logic         hv [LEVELS+1][P];
  logic [W-1:0] dv [LEVELS+1][P];

  genvar l, j;

  // Gate leaf data with its hit flag, pad the unused leaves
  for (j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign hv[0][j] = hit[j];
      assign dv[0][j] = hit[j] ? data[j] : '0;
    end else begin : g_pad
      assign hv[0][j] = 1'b0;
      assign dv[0][j] = '0;
    end
  end

  // Merge four nodes per level, one register stage each
  for (l = 1; l <= LEVELS; l++) begin : g_lvl
    for (j = 0; j < (P >> (2 * l)); j++) begin : g_node
      always_ff @(posedge clk) begin
        hv[l][j] <= hv[l-1][4*j] | hv[l-1][4*j+1] | hv[l-1][4*j+2] | hv[l-1][4*j+3];
        dv[l][j] <= dv[l-1][4*j] | dv[l-1][4*j+1] | dv[l-1][4*j+2] | dv[l-1][4*j+3];
      end
    end
  end

  assign any = hv[LEVELS][0];
  assign sel = dv[LEVELS][0];

endmodule

### rtl/sorted_id_set_indexed_update.sv
// Sorted identifier set: top level with cell row, rank tree and control.
//
// Holds up to CAPACITY unique identifiers in ascending order in a row of
// compare-and-shift cells and takes one lookup, insert, remove or clear per
// item, returning one result per item. From acceptance until its result is
// loaded, each item passes through these steps in order: every cell compares
// its entry with the key and holds the flags, then each level of the
// registered four-way tree that finds the rank and presence, and last the
// row is shifted and the result is loaded into the output register. The next item
// is accepted in the cycle after the previous result is loaded into the
// output register, even while that result still waits to be taken; a result
// that is still waiting holds the following one back until it is taken.
// Identifiers are reduced to their low ID_BITS bits. Position and entry
// count are reported modulo 2048.
module sorted_id_set_indexed_update #(
  parameter int CAPACITY = 1024,
  parameter int ID_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [31:0]                   key_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [sisiu_pkg::POS_W-1:0]   position,
  output logic [1:0]                    event_res,
  output logic                          full_refused,
  output logic [sisiu_pkg::POS_W-1:0]   entry_count
);

  import sisiu_pkg::*;

  localparam int LW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
  localparam int WCW    = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WAIT,
    S_DONE
  } state_t;

  state_t             state;
  op_t                op_q;
  logic [ID_BITS-1:0] key_q;
  logic [CW-1:0]      count;
  logic [WCW-1:0]     wcnt;

  logic [ID_BITS+31:0] key_wide;
  logic [ID_BITS-1:0]  key_in;

  cell_cmd_t          cmd;
  logic [ID_BITS-1:0] ent       [CAPACITY];
  logic [ID_BITS-1:0] left_ent  [CAPACITY];
  logic [ID_BITS-1:0] right_ent [CAPACITY];
  logic               ltv       [CAPACITY];
  logic               eqv       [CAPACITY];
  logic               left_ltv  [CAPACITY];
  logic               cvalid    [CAPACITY];

  logic [CAPACITY-1:0]       first;
  logic [CAPACITY-1:0][LW:0] leaf;
  logic                      tree_hit;
  logic [LW:0]               tree_sel;

  logic          fire;
  logic          present;
  logic          full;
  logic [LW-1:0] rank_idx;
  logic          res_found;
  logic          res_use_pos;
  ev_t           res_ev;
  logic          res_refused;
  logic [CW-1:0] count_next;

  logic [LW+POS_W-1:0] pos_ext;
  logic [CW+POS_W-1:0] cnt_ext;

  // Reduce the key to the identifier width
  assign key_wide = {{ID_BITS{1'b0}}, key_id};
  assign key_in   = key_wide[ID_BITS-1:0];

  // Build the cell row with its neighbor links
  genvar i;
  for (i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_ltv[i] = 1'b1;
      assign left_ent[i] = ent[i];
    end else begin : g_body
      assign left_ltv[i] = ltv[i-1];
      assign left_ent[i] = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent[i] = ent[i];
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end

    assign cvalid[i] = CW'(i) < count;

    // Mark the first cell not below the key: it sits at the rank
    assign first[i] = !ltv[i] && left_ltv[i];
    assign leaf[i]  = {eqv[i], LW'(i)};

    sisiu_cell #(
      .ID_W (ID_BITS)
    ) u_cell (
      .clk         (clk),
      .key         (key_q),
      .valid       (cvalid[i]),
      .cmd         (cmd),
      .left_ltv    (left_ltv[i]),
      .left_entry  (left_ent[i]),
      .right_entry (right_ent[i]),
      .entry       (ent[i]),
      .ltv         (ltv[i]),
      .eqv         (eqv[i])
    );
  end

  sisiu_tree #(
    .N (CAPACITY),
    .W (LW + 1)
  ) u_tree (
    .clk  (clk),
    .hit  (first),
    .data (leaf),
    .any  (tree_hit),
    .sel  (tree_sel)
  );

  assign fire     = (state == S_DONE) && (!out_valid || out_ready);
  assign present  = tree_hit && tree_sel[LW];
  assign rank_idx = tree_sel[LW-1:0];
  assign full     = count == CW'(CAPACITY);

  // Decide the result and the row update
  always_comb begin
    res_found   = 1'b0;
    res_use_pos = 1'b0;
    res_ev      = EV_NONE;
    res_refused = 1'b0;
    count_next  = count;
    cmd         = '0;
    cmd.capture = state == S_CMP;
    case (op_q)
      OP_LOOKUP: begin
        res_found   = present;
        res_use_pos = present;
      end
      OP_INSERT: begin
        if (present) begin
          res_found   = 1'b1;
          res_use_pos = 1'b1;
        end else if (full) begin
          res_refused = 1'b1;
        end else begin
          res_use_pos = 1'b1;
          res_ev      = EV_INSERTED;
          count_next  = count + CW'(1);
          cmd.ins     = fire;
        end
      end
      OP_REMOVE: begin
        if (present) begin
          res_found   = 1'b1;
          res_use_pos = 1'b1;
          res_ev      = EV_REMOVED;
          count_next  = count - CW'(1);
          cmd.rem     = fire;
        end
      end
      OP_CLEAR: begin
        if (count != '0) begin
          res_ev     = EV_RESET;
          count_next = '0;
        end
      end
      default: begin
        res_ev = EV_NONE;
      end
    endcase
  end

  assign pos_ext = {{POS_W{1'b0}}, (res_use_pos ? rank_idx : '0)};
  assign cnt_ext = {{POS_W{1'b0}}, count_next};

  assign in_ready = state == S_IDLE;

  // Sequence the item and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      wcnt      <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op_t'(op);
            key_q <= key_in;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          wcnt  <= WCW'(LEVELS - 1);
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (wcnt == '0) begin
            state <= S_DONE;
          end else begin
            wcnt <= wcnt - WCW'(1);
          end
        end
        S_DONE: begin
          if (fire) begin
            count        <= count_next;
            found        <= res_found;
            position     <= pos_ext[POS_W-1:0];
            event_res    <= res_ev;
            full_refused <= res_refused;
            entry_count  <= cnt_ext[POS_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Count never exceeds the table size
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A refused insert never reports a present identifier
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(found && full_refused))
    else $error("found and refused together");

  // A reset event leaves the set empty
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_RESET) |-> entry_count == '0)
    else $error("reset event with entries left");

  // An insert grows the set by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (fire && res_ev == EV_INSERTED) |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the set by one");

  // Held entries stay strictly ascending
  for (i = 0; i < CAPACITY - 1; i++) begin : g_order_chk
    assert property (@(posedge clk) disable iff (rst)
      (CW'(i + 1) < count && state == S_IDLE) |-> ent[i] < ent[i+1])
      else $error("entries out of order");
  end

endmodule
